// ===== src/pss_pkg.sv =====
// pss_pkg: shared types and constants of the periodic slot scheduler
// depends on nothing; used by pss_ctrl and periodic_slot_scheduler_core
`timescale 1ns / 1ps

package pss_pkg;

  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned DEF_SLOTS   = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned REP_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_PAUSE  = 3'd2,
    ACT_RESUME = 3'd3,
    ACT_SET    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESUME,
    ST_WALK
  } state_e;

endpackage

// ===== src/pss_slot_ram.sv =====
// pss_slot_ram: slot table memory, one write port and one registered read port
// holds interval and counter of every slot; no package dependency
`timescale 1ns / 1ps

module pss_slot_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pss_ctrl.sv =====
// pss_ctrl: command decode, slot flags, tick walk over the slot memory and result register
// depends on pss_pkg; drives the ports of pss_slot_ram
`timescale 1ns / 1ps

module pss_ctrl #(
  parameter int unsigned SLOTS = pss_pkg::DEF_SLOTS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pss_pkg::ACTION_W-1:0]         action_i,
  input  logic [pss_pkg::SLOT_W-1:0]           slot_i,
  input  logic [pss_pkg::PERIOD_W-1:0]         period_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [pss_pkg::SLOT_W-1:0]           due_slot_o,
  output logic                                 last_due_o,
  output logic                                 ram_we_o,
  output logic [$clog2(SLOTS)-1:0]             ram_waddr_o,
  output logic [2*pss_pkg::PERIOD_W-1:0]       ram_wdata_o,
  output logic                                 ram_re_o,
  output logic [$clog2(SLOTS)-1:0]             ram_raddr_o,
  input  logic [2*pss_pkg::PERIOD_W-1:0]       ram_rdata_i
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned PW    = pss_pkg::PERIOD_W;

  pss_pkg::state_e  state_q, state_d;
  pss_pkg::action_e act;

  logic [SLOTS-1:0]              en_q, en_d;
  logic [SLOTS-1:0]              reg_q, reg_d;
  logic [CNT_W-1:0]              issue_q, issue_d;
  logic                          rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]              rd_idx_q, rd_idx_d;
  logic [pss_pkg::REP_W-1:0]     rep_q, rep_d;
  logic                          pend_vld_q, pend_vld_d;
  logic [pss_pkg::SLOT_W-1:0]    pend_slot_q, pend_slot_d;
  logic                          out_vld_q, out_vld_d;
  logic [pss_pkg::SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic                          out_last_q, out_last_d;

  logic             slot_ok;
  logic [IDX_W-1:0] sidx;
  logic [PW-1:0]    intv;
  logic [PW-1:0]    cnt_dec;
  logic             cur_act;
  logic             is_zero;
  logic             report;
  logic             hold;
  logic             out_free;
  logic             out_load;

  assign act      = pss_pkg::action_e'(action_i);
  assign slot_ok  = 32'(slot_i) < SLOTS;
  assign sidx     = IDX_W'(slot_i);
  assign intv     = ram_rdata_i[2*PW-1:PW];
  assign cnt_dec  = ram_rdata_i[PW-1:0] - {{(PW-1){1'b0}}, 1'b1};
  assign is_zero  = (cnt_dec == '0);
  assign cur_act  = rd_vld_q && en_q[rd_idx_q] && reg_q[rd_idx_q];
  assign report   = cur_act && is_zero && (rep_q < pss_pkg::REP_W'(pss_pkg::MAX_RESULTS));
  assign out_free = !out_vld_q || !out_stall_i;
  assign hold     = report && pend_vld_q && !out_free;

  always_comb begin
    state_d     = state_q;
    en_d        = en_q;
    reg_d       = reg_q;
    issue_d     = issue_q;
    rd_vld_d    = rd_vld_q;
    rd_idx_d    = rd_idx_q;
    rep_d       = rep_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    out_load    = 1'b0;
    out_slot_d  = out_slot_q;
    out_last_d  = out_last_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = rd_idx_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = issue_q[IDX_W-1:0];
    in_stall_o  = (state_q != pss_pkg::ST_IDLE);

    case (state_q)
      pss_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (act)
            pss_pkg::ACT_TICK: begin
              state_d  = pss_pkg::ST_WALK;
              issue_d  = '0;
              rd_vld_d = 1'b0;
              rep_d    = '0;
            end
            pss_pkg::ACT_ADD: begin
              if (slot_ok) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = sidx;
                ram_wdata_o = {period_i, period_i};
                en_d[sidx]  = 1'b1;
                reg_d[sidx] = 1'b1;
              end
            end
            pss_pkg::ACT_PAUSE: begin
              if (slot_ok) begin
                en_d[sidx] = 1'b0;
              end
            end
            pss_pkg::ACT_RESUME: begin
              if (slot_ok && reg_q[sidx]) begin
                en_d[sidx]  = 1'b1;
                ram_re_o    = 1'b1;
                ram_raddr_o = sidx;
                rd_idx_d    = sidx;
                state_d     = pss_pkg::ST_RESUME;
              end
            end
            pss_pkg::ACT_SET: begin
              if (slot_ok) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = sidx;
                ram_wdata_o = {period_i, period_i};
              end
            end
            default: ;
          endcase
        end
      end

      pss_pkg::ST_RESUME: begin
        // reload counter from the interval just read
        ram_we_o    = 1'b1;
        ram_waddr_o = rd_idx_q;
        ram_wdata_o = {intv, intv};
        state_d     = pss_pkg::ST_IDLE;
      end

      pss_pkg::ST_WALK: begin
        if (!hold) begin
          if (cur_act) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = rd_idx_q;
            ram_wdata_o = {intv, is_zero ? intv : cnt_dec};
          end
          if (report) begin
            if (pend_vld_q) begin
              out_load   = 1'b1;
              out_slot_d = pend_slot_q;
              out_last_d = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_slot_d = pss_pkg::SLOT_W'(rd_idx_q);
            rep_d       = rep_q + 1'b1;
          end
          if (issue_q < CNT_W'(SLOTS)) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = issue_q[IDX_W-1:0];
            rd_idx_d    = issue_q[IDX_W-1:0];
            rd_vld_d    = 1'b1;
            issue_d     = issue_q + 1'b1;
          end else begin
            rd_vld_d = 1'b0;
          end
          // walk finished: last pending report goes out flagged
          if ((issue_q == CNT_W'(SLOTS)) && !rd_vld_q) begin
            if (pend_vld_q) begin
              if (out_free) begin
                out_load   = 1'b1;
                out_slot_d = pend_slot_q;
                out_last_d = 1'b1;
                pend_vld_d = 1'b0;
                state_d    = pss_pkg::ST_IDLE;
              end
            end else begin
              state_d = pss_pkg::ST_IDLE;
            end
          end
        end
      end

      default: state_d = pss_pkg::ST_IDLE;
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pss_pkg::ST_IDLE;
      en_q       <= '0;
      reg_q      <= '0;
      issue_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      rep_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      en_q       <= en_d;
      reg_q      <= reg_d;
      issue_q    <= issue_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
      rep_q      <= rep_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    out_slot_q  <= out_slot_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_vld_q;
  assign due_slot_o  = out_slot_q;
  assign last_due_o  = out_last_q;

`ifndef SYNTHESIS
  a_rep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q <= pss_pkg::REP_W'(pss_pkg::MAX_RESULTS))
    else $error("report count above limit");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o && (ram_waddr_o == ram_raddr_o)))
    else $error("read and write of the same slot in one cycle");

  a_walk_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pss_pkg::ST_WALK && state_d == pss_pkg::ST_IDLE) |=> !pend_vld_q)
    else $error("walk ended with a report still pending");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten while stalled");

  a_tick_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && act == pss_pkg::ACT_TICK) |=>
      (state_q == pss_pkg::ST_WALK))
    else $error("tick did not start a walk");
`endif

endmodule

// ===== src/periodic_slot_scheduler_core.sv =====
// periodic_slot_scheduler_core: top level of the periodic slot scheduler
// depends on pss_pkg, pss_slot_ram and pss_ctrl
//
// input channel (in_valid_i / in_stall_o): one command per transaction, action_i
// selects tick, add, pause, resume or set interval, slot_i and period_i give the
// slot and its interval. output channel (out_valid_o / out_stall_i): one transaction
// per slot that came due on a tick, in slot order, last_due_o marks the final one.
// add, pause and set interval are done in the idle state; resume reads the interval and
// then writes the counter. a tick walks the slot memory one entry per cycle, unless held,
// through its single read port and single write port; the walk is held while the output
// is stalled while two reports are already waiting. a due slot is held
// back until the next due slot or the end of the walk shows whether it is the last,
// so the first result appears at the second due slot or at the end of the walk.
// a result waits in an output register; a new command is taken while it waits.
// reset clears the enabled and registered marks of every slot and empties the
// output; the interval and counter memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module periodic_slot_scheduler_core #(
  parameter int unsigned SLOTS = pss_pkg::DEF_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pss_pkg::ACTION_W-1:0] action_i,
  input  logic [pss_pkg::SLOT_W-1:0]   slot_i,
  input  logic [pss_pkg::PERIOD_W-1:0] period_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pss_pkg::SLOT_W-1:0]   due_slot_o,
  output logic                         last_due_o
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned WORD_W = 2 * pss_pkg::PERIOD_W;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  pss_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .slot_i      (slot_i),
    .period_i    (period_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .due_slot_o  (due_slot_o),
    .last_due_o  (last_due_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pss_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (WORD_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
